// ----- sv/dhf_pkg.sv -----
// ----------------------------------------------------------------------------
// dhf_pkg: shared constants for the dihedral angle and frame block
// Holds the square root width, the CORDIC step count, the angle constants in
// Q30 and the arctangent table used by the vectoring unit.
// ----------------------------------------------------------------------------
package dhf_pkg;

  // Radicand width of the shared square root unit (sums stay below 2^62).
  localparam int SQ_W = 62;

  // Number of CORDIC vectoring steps and width of its working registers.
  localparam int CORDIC_STEPS = 30;
  localparam int CORD_W       = 34;

  // Angle constants in Q30.
  localparam logic [CORD_W-1:0] PI_Q30      = 34'd3373259426;
  localparam logic [CORD_W-1:0] HALF_PI_Q30 = 34'd1686629713;

  // Arctangent of 2^-i in Q30; from step ten on it equals 2^(30-i).
  function automatic logic [CORD_W-1:0] atan_q30(input logic [4:0] i);
    logic [CORD_W-1:0] ang;
    case (i)
      5'd0:    ang = 34'd843314857;
      5'd1:    ang = 34'd497837829;
      5'd2:    ang = 34'd263043837;
      5'd3:    ang = 34'd133525159;
      5'd4:    ang = 34'd67021687;
      5'd5:    ang = 34'd33543516;
      5'd6:    ang = 34'd16775851;
      5'd7:    ang = 34'd8388437;
      5'd8:    ang = 34'd4194283;
      5'd9:    ang = 34'd2097149;
      default: ang = 34'h0_4000_0000 >> i;
    endcase
    return ang;
  endfunction

endpackage

// ----- sv/dhf_isqrt.sv -----
// ----------------------------------------------------------------------------
// dhf_isqrt: iterative integer square root
// Bit-pair restoring square root, one result bit per cycle. The root is
// floor(sqrt(value)) and is valid in the cycle in which done is high.
// ----------------------------------------------------------------------------
module dhf_isqrt (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [dhf_pkg::SQ_W-1:0]    value,
  output logic                        done,
  output logic [dhf_pkg::SQ_W/2-1:0]  root
);

  localparam int W = dhf_pkg::SQ_W;

  logic [W-1:0] rem;
  logic [W-1:0] res;
  logic [W-1:0] bitv;
  logic         run;
  logic [W-1:0] trial;

  assign trial = res + bitv;
  assign root  = res[W/2-1:0];

  // One bit pair of the radicand is consumed per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && run && (bitv == W'(1));
      if (start) begin
        rem  <= value;
        res  <= '0;
        bitv <= W'(1) << (W - 2);
        run  <= 1'b1;
      end else if (run) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) + bitv;
        end else begin
          res <= res >> 1;
        end
        bitv <= bitv >> 2;
        if (bitv == W'(1)) begin
          run <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- sv/dhf_cordic.sv -----
// ----------------------------------------------------------------------------
// dhf_cordic: CORDIC vectoring unit for the arccosine
// Takes the cosine d and sine s of an angle in Q30, pre-rotates by a quarter
// turn when d is negative, runs the vectoring steps one per cycle and gives
// the angle in Q30, clamped to zero through pi.
// ----------------------------------------------------------------------------
module dhf_cordic (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] cos_q30,
  input  logic [30:0]        sin_q30,
  output logic               done,
  output logic [31:0]        angle
);

  localparam int CW = dhf_pkg::CORD_W;

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [CW-1:0] z;
  logic [4:0]           step;
  logic                 run;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] ang;

  assign dx  = y >>> step;
  assign dy  = x >>> step;
  assign ang = dhf_pkg::atan_q30(step);

  // Clamp the accumulated angle to the range zero through pi.
  always_comb begin
    if (z < 0) begin
      angle = '0;
    end else if (z > $signed(dhf_pkg::PI_Q30)) begin
      angle = dhf_pkg::PI_Q30[31:0];
    end else begin
      angle = z[31:0];
    end
  end

  // Rotate toward the x axis one step per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && run && (step == 5'(dhf_pkg::CORDIC_STEPS - 1));
      if (start) begin
        step <= '0;
        run  <= 1'b1;
        if (cos_q30 < 0) begin
          x <= $signed({3'b000, sin_q30});
          y <= -CW'(cos_q30);
          z <= $signed(dhf_pkg::HALF_PI_Q30);
        end else begin
          x <= CW'(cos_q30);
          y <= $signed({3'b000, sin_q30});
          z <= '0;
        end
      end else if (run) begin
        if (y > 0) begin
          x <= x + dx;
          y <= y - dy;
          z <= z + ang;
        end else begin
          x <= x - dx;
          y <= y + dy;
          z <= z - ang;
        end
        step <= step + 5'd1;
        if (step == 5'(dhf_pkg::CORDIC_STEPS - 1)) begin
          run <= 1'b0;
        end
      end
    end
  end

endmodule

// ----- sv/dihedral_angle_and_frame.sv -----
// ----------------------------------------------------------------------------
// dihedral_angle_and_frame: dihedral angle and local frame from four points
// Collects four 3-D points, forms the unit bond directions and normals with
// one shared multiplier, a bit-serial square root and a one-bit-per-cycle
// divider, finds the signed dihedral angle with a CORDIC unit and sends the
// three upper rows of the local frame.
//
//   channel   handshake             word
//   --------  --------------------  ---------------------------------------
//   point     start / busy          x_coord, y_coord, z_coord
//   row       row_valid (strobe)    row_index, col_x_axis, col_y_axis,
//                                   col_z_axis, col_origin, dihedral,
//                                   degenerate, last_row
//
// The first three points of a set are taken without raising busy. The fourth
// keeps busy high while up to seven unit vectors are formed, each with a shift
// normalization, the multiply steps for a cross product, the squares, the
// square root and the divider, plus the arccosine. The three row words then
// follow on consecutive cycles.
// Reset (rst, synchronous) empties the point count and drops any result.
// The receiver cannot stall: each row word is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module dihedral_angle_and_frame #(
  parameter int FRAC_BITS   = 16,
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] x_coord,
  input  logic signed [COORD_WIDTH-1:0] y_coord,
  input  logic signed [COORD_WIDTH-1:0] z_coord,
  output logic                          row_valid,
  output logic [1:0]                    row_index,
  output logic signed [17:0]            col_x_axis,
  output logic signed [17:0]            col_y_axis,
  output logic signed [17:0]            col_z_axis,
  output logic signed [COORD_WIDTH-1:0] col_origin,
  output logic signed [18:0]            dihedral,
  output logic                          degenerate,
  output logic                          last_row
);

  localparam int CW     = COORD_WIDTH;
  localparam int UW     = FRAC_BITS + 2;
  localparam int QB     = FRAC_BITS + 2;
  localparam int ACC_W  = 2 * FRAC_BITS + 4;
  localparam int SW0    = (CW + 2 > ACC_W) ? CW + 2 : ACC_W;
  localparam int SW     = (SW0 > 32) ? SW0 : 32;
  localparam int NW     = 31 + FRAC_BITS;
  localparam int AW     = FRAC_BITS + 4;
  localparam int DCW    = $clog2(QB);
  localparam int SQ_W   = dhf_pkg::SQ_W;
  localparam int DSH_R  = (2 * FRAC_BITS >= 30) ? 2 * FRAC_BITS - 30 : 0;
  localparam int DSH_L  = (2 * FRAC_BITS < 30) ? 30 - 2 * FRAC_BITS : 0;
  localparam logic [32:0] RND = 33'd1 << (29 - FRAC_BITS);

  // Job codes: which vector the sequencer is working on.
  localparam logic [3:0] JOB_PREV = 4'd0;
  localparam logic [3:0] JOB_ZAX  = 4'd1;
  localparam logic [3:0] JOB_FWD  = 4'd2;
  localparam logic [3:0] JOB_N1   = 4'd3;
  localparam logic [3:0] JOB_XAX  = 4'd4;
  localparam logic [3:0] JOB_YAX  = 4'd5;
  localparam logic [3:0] JOB_ACOS = 4'd6;
  localparam logic [3:0] JOB_DIR  = 4'd7;
  localparam logic [3:0] JOB_SIGN = 4'd8;

  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_LOAD    = 16'h0002,
    S_XMUL    = 16'h0004,
    S_XACC    = 16'h0008,
    S_NORM    = 16'h0010,
    S_SQMUL   = 16'h0020,
    S_SQACC   = 16'h0040,
    S_SQRT    = 16'h0080,
    S_DIVINIT = 16'h0100,
    S_DIV     = 16'h0200,
    S_STORE   = 16'h0400,
    S_D2MUL   = 16'h0800,
    S_D2SUB   = 16'h1000,
    S_ASQRT   = 16'h2000,
    S_CORD    = 16'h4000,
    S_EMIT    = 16'h8000
  } state_t;

  typedef logic signed [UW-1:0] uvec_t [3];

  state_t state;
  logic [3:0] job;
  logic [2:0] k;
  logic [1:0] points_held;
  logic [1:0] row;
  logic       ok;

  logic signed [CW-1:0] p1 [3];
  logic signed [CW-1:0] p2 [3];
  logic signed [CW-1:0] p3 [3];
  logic signed [CW-1:0] p4 [3];

  uvec_t u_prev, u_zax, u_fwd, u_n1, u_xax, u_yax, u_dir, u_q;
  uvec_t va, vb;

  logic          neg [3];
  logic [SW-1:0] mag [3];
  logic [SW-1:0] mmax;

  logic signed [ACC_W-1:0] acc;
  logic signed [ACC_W-1:0] prodt;
  logic signed [ACC_W-1:0] acc_sum;
  logic signed [ACC_W-1:0] cval;
  logic signed [SW-1:0]    cext;
  logic [SQ_W-1:0]         sum;
  logic [SQ_W-1:0]         sum_next;
  logic [30:0]             nrm;

  logic [31:0]     div_rem;
  logic [QB-1:0]   div_low;
  logic [QB-1:0]   div_q;
  logic [DCW-1:0]  div_cnt;
  logic [NW-1:0]   numer;
  logic [32:0]     div_r2;
  logic            div_ge;
  logic [QB-1:0]   q_fin;

  logic signed [31:0] dq;
  logic signed [31:0] dq_next;
  logic signed [AW-1:0] angle;
  logic [32:0]        ang_rnd;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod;
  logic [1:0]         ia, ib;
  logic               is_cross;

  logic            sq_start, sq_done;
  logic [SQ_W-1:0] sq_value;
  logic [30:0]     sq_root;
  logic            cord_start, cord_done;
  logic [31:0]     cord_angle;

  logic signed [SW-1:0] dsub [3];

  function automatic logic [17:0] fit18(input logic signed [UW-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[17:0];
  endfunction

  function automatic logic [18:0] fit19(input logic signed [AW-1:0] v);
    logic signed [63:0] w;
    w = 64'(v);
    return w[18:0];
  endfunction

  assign busy = (state != S_IDLE);

  // Shared units.
  dhf_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .value (sq_value),
    .done  (sq_done),
    .root  (sq_root)
  );

  dhf_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cord_start),
    .cos_q30 (dq),
    .sin_q30 (sq_root),
    .done    (cord_done),
    .angle   (cord_angle)
  );

  // Operand vectors for the cross and dot product jobs.
  always_comb begin
    case (job)
      JOB_N1:   begin va = u_prev; vb = u_zax; end
      JOB_XAX:  begin va = u_zax;  vb = u_fwd; end
      JOB_YAX:  begin va = u_zax;  vb = u_xax; end
      JOB_ACOS: begin va = u_n1;   vb = u_xax; end
      JOB_DIR:  begin va = u_n1;   vb = u_xax; end
      JOB_SIGN: begin va = u_zax;  vb = u_dir; end
      default:  begin va = u_prev; vb = u_prev; end
    endcase
  end

  // Component indexes for the current product term.
  assign is_cross = (job != JOB_ACOS) && (job != JOB_SIGN);
  always_comb begin
    if (is_cross) begin
      case (k[2:1])
        2'd0:    begin ia = k[0] ? 2'd2 : 2'd1; ib = k[0] ? 2'd1 : 2'd2; end
        2'd1:    begin ia = k[0] ? 2'd0 : 2'd2; ib = k[0] ? 2'd2 : 2'd0; end
        default: begin ia = k[0] ? 2'd1 : 2'd0; ib = k[0] ? 2'd0 : 2'd1; end
      endcase
    end else begin
      ia = k[1:0];
      ib = k[1:0];
    end
  end

  // The one multiplier, shared by products, squares and the cosine square.
  always_comb begin
    case (state)
      S_XMUL: begin
        mul_a = 32'(va[ia]);
        mul_b = 32'(vb[ib]);
      end
      S_SQMUL: begin
        mul_a = 32'(mag[k[1:0]][29:0]);
        mul_b = 32'(mag[k[1:0]][29:0]);
      end
      S_D2MUL: begin
        mul_a = dq;
        mul_b = dq;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign prodt   = prod[ACC_W-1:0];
  assign acc_sum = acc + prodt;
  assign cval    = acc - prodt;
  assign cext    = SW'(cval);
  assign sum_next = ((k == 3'd0) ? '0 : sum) + prod[SQ_W-1:0];

  // Point differences for the bond direction jobs.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (job)
        JOB_PREV: dsub[i] = SW'(p2[i]) - SW'(p1[i]);
        JOB_ZAX:  dsub[i] = SW'(p3[i]) - SW'(p2[i]);
        default:  dsub[i] = SW'(p4[i]) - SW'(p3[i]);
      endcase
    end
  end

  // Largest component magnitude for the normalizing shift.
  always_comb begin
    mmax = (mag[0] > mag[1]) ? mag[0] : mag[1];
    if (mag[2] > mmax) begin
      mmax = mag[2];
    end
  end

  // Divider numerator, with the half-divisor rounding term folded in.
  assign numer  = (NW'(mag[k[1:0]][29:0]) << FRAC_BITS) + NW'(nrm[30:1]);
  assign div_r2 = {div_rem, div_low[QB-1]};
  assign div_ge = (div_r2 >= {2'b00, nrm});
  assign q_fin  = {div_q[QB-2:0], div_ge};

  // Cosine in Q30, truncated toward zero and saturated to plus or minus one.
  always_comb begin
    logic signed [63:0] a64;
    logic [63:0]        am;
    logic signed [63:0] t64;
    a64 = 64'(acc_sum);
    am  = (a64 < 0) ? 64'(-a64) : 64'(a64);
    am  = (am >> DSH_R) << DSH_L;
    t64 = (a64 < 0) ? -$signed(am) : $signed(am);
    if (t64 > 64'sd1073741824) begin
      t64 = 64'sd1073741824;
    end else if (t64 < -64'sd1073741824) begin
      t64 = -64'sd1073741824;
    end
    dq_next = t64[31:0];
  end

  // Square root requests come from the norm and from the sine.
  assign sq_start = ((state == S_SQACC) && (k == 3'd2)) || (state == S_D2SUB);
  assign sq_value = (state == S_D2SUB) ? (SQ_W'(62'd1 << 60) - prod[SQ_W-1:0]) : sum_next;
  assign cord_start = (state == S_ASQRT) && sq_done;
  assign ang_rnd = ({1'b0, cord_angle} + RND) >> (30 - FRAC_BITS);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      points_held <= '0;
      row         <= '0;
      row_valid   <= 1'b0;
    end else begin
      row_valid <= (state == S_EMIT);
      case (state)
        S_IDLE: begin
          if (start) begin
            case (points_held)
              2'd0: begin p1[0] <= x_coord; p1[1] <= y_coord; p1[2] <= z_coord; end
              2'd1: begin p2[0] <= x_coord; p2[1] <= y_coord; p2[2] <= z_coord; end
              2'd2: begin p3[0] <= x_coord; p3[1] <= y_coord; p3[2] <= z_coord; end
              default: begin
                p4[0] <= x_coord; p4[1] <= y_coord; p4[2] <= z_coord;
              end
            endcase
            if (points_held == 2'd3) begin
              points_held <= '0;
              job         <= JOB_PREV;
              ok          <= 1'b1;
              angle       <= '0;
              state       <= S_LOAD;
            end else begin
              points_held <= points_held + 2'd1;
            end
          end
        end

        S_LOAD: begin
          acc <= '0;
          k   <= '0;
          if (job == JOB_PREV || job == JOB_ZAX || job == JOB_FWD) begin
            for (int i = 0; i < 3; i++) begin
              neg[i] <= dsub[i] < 0;
              mag[i] <= (dsub[i] < 0) ? SW'(-dsub[i]) : SW'(dsub[i]);
            end
            state <= S_NORM;
          end else begin
            state <= S_XMUL;
          end
        end

        S_XMUL: begin
          state <= S_XACC;
        end

        // Accumulate one product term.
        S_XACC: begin
          if (is_cross) begin
            if (!k[0]) begin
              acc <= prodt;
            end else begin
              neg[k[2:1]] <= cext < 0;
              mag[k[2:1]] <= (cext < 0) ? SW'(-cext) : SW'(cext);
            end
            if (k == 3'd5) begin
              state <= S_NORM;
            end else begin
              k     <= k + 3'd1;
              state <= S_XMUL;
            end
          end else begin
            acc <= acc_sum;
            if (k == 3'd2) begin
              if (job == JOB_ACOS) begin
                dq    <= dq_next;
                state <= S_D2MUL;
              end else begin
                if (acc_sum < 0) begin
                  angle <= -angle;
                end
                state <= S_EMIT;
              end
            end else begin
              k     <= k + 3'd1;
              state <= S_XMUL;
            end
          end
        end

        // Shift the magnitudes until the largest lies in [2^29, 2^30).
        S_NORM: begin
          if (mmax == '0) begin
            if (job != JOB_DIR) begin
              ok <= 1'b0;
              angle <= '0;
            end
            state <= S_EMIT;
          end else if (mmax >= (SW'(1) << 30)) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] >> 1;
            end
          end else if (mmax < (SW'(1) << 29)) begin
            for (int i = 0; i < 3; i++) begin
              mag[i] <= mag[i] << 1;
            end
          end else begin
            k     <= '0;
            state <= S_SQMUL;
          end
        end

        S_SQMUL: begin
          state <= S_SQACC;
        end

        S_SQACC: begin
          sum <= sum_next;
          if (k == 3'd2) begin
            state <= S_SQRT;
          end else begin
            k     <= k + 3'd1;
            state <= S_SQMUL;
          end
        end

        S_SQRT: begin
          if (sq_done) begin
            nrm   <= sq_root;
            k     <= '0;
            state <= S_DIVINIT;
          end
        end

        S_DIVINIT: begin
          div_rem <= 32'(numer >> QB);
          div_low <= numer[QB-1:0];
          div_q   <= '0;
          div_cnt <= '0;
          state   <= S_DIV;
        end

        // Restoring division, one quotient bit per cycle.
        S_DIV: begin
          div_rem <= div_ge ? 32'(div_r2 - {2'b00, nrm}) : div_r2[31:0];
          div_low <= div_low << 1;
          div_q   <= q_fin;
          div_cnt <= div_cnt + DCW'(1);
          if (div_cnt == DCW'(QB - 1)) begin
            u_q[k[1:0]] <= neg[k[1:0]] ? -$signed(q_fin) : $signed(q_fin);
            if (k == 3'd2) begin
              state <= S_STORE;
            end else begin
              k     <= k + 3'd1;
              state <= S_DIVINIT;
            end
          end
        end

        S_STORE: begin
          case (job)
            JOB_PREV: u_prev <= u_q;
            JOB_ZAX:  u_zax  <= u_q;
            JOB_FWD:  u_fwd  <= u_q;
            JOB_N1:   u_n1   <= u_q;
            JOB_XAX:  u_xax  <= u_q;
            JOB_YAX:  u_yax  <= u_q;
            default:  u_dir  <= u_q;
          endcase
          job   <= job + 4'd1;
          state <= S_LOAD;
        end

        S_D2MUL: begin
          state <= S_D2SUB;
        end

        S_D2SUB: begin
          state <= S_ASQRT;
        end

        S_ASQRT: begin
          if (sq_done) begin
            state <= S_CORD;
          end
        end

        S_CORD: begin
          if (cord_done) begin
            angle <= ang_rnd[AW-1:0];
            job   <= JOB_DIR;
            state <= S_LOAD;
          end
        end

        // Send the three frame rows on consecutive cycles.
        S_EMIT: begin
          row_index  <= row;
          col_x_axis <= ok ? fit18(u_xax[row]) : '0;
          col_y_axis <= ok ? fit18(u_yax[row]) : '0;
          col_z_axis <= ok ? fit18(u_zax[row]) : '0;
          col_origin <= p3[row];
          dihedral   <= ok ? fit19(angle) : '0;
          degenerate <= !ok;
          last_row   <= (row == 2'd2);
          if (row == 2'd2) begin
            row   <= '0;
            state <= S_IDLE;
          end else begin
            row <= row + 2'd1;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Rows of one result come back to back and in order.
  a_rows_in_order: assert property (@(posedge clk) disable iff (rst)
    row_valid && !last_row |=> row_valid && (row_index == 2'($past(row_index) + 2'd1)))
    else $error("frame rows not consecutive");

  // A degenerate result carries no axes and no angle.
  a_degenerate_zero: assert property (@(posedge clk) disable iff (rst)
    row_valid && degenerate |-> (col_x_axis == '0) && (col_y_axis == '0) &&
                                (col_z_axis == '0) && (dihedral == '0))
    else $error("degenerate row carries nonzero data");

  // The square root only finishes while the sequencer waits for it.
  a_sqrt_expected: assert property (@(posedge clk) disable iff (rst)
    sq_done |-> (state == S_SQRT) || (state == S_ASQRT))
    else $error("square root finished outside a wait state");

endmodule

// ----- bench/dihedral_angle_and_frame_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dihedral_angle_and_frame_test: self-checking bench for the dihedral block
// Feeds sets of four points with random gaps, predicts the three frame rows
// of every set in fixed point and checks each row word field by field.
// ----------------------------------------------------------------------------
module dihedral_angle_and_frame_test;

  typedef longint vec3_t [3];

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    bit                 drain;
  } point_t;

  typedef struct {
    logic [1:0]         idx;
    logic signed [17:0] xa;
    logic signed [17:0] ya;
    logic signed [17:0] za;
    logic signed [31:0] org;
    logic signed [18:0] ang;
    logic               degen;
    logic               last;
  } frame_row_t;

  localparam int     FRAC        = 16;
  localparam longint PI_Q30_L    = 64'sd3373259426;
  localparam longint HALF_PI_L   = 64'sd1686629713;
  localparam int     IDLE_LIMIT  = 20000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] x_coord = '0;
  logic signed [31:0] y_coord = '0;
  logic signed [31:0] z_coord = '0;
  logic               row_valid;
  logic [1:0]         row_index;
  logic signed [17:0] col_x_axis, col_y_axis, col_z_axis;
  logic signed [31:0] col_origin;
  logic signed [18:0] dihedral;
  logic               degenerate, last_row;

  point_t     pending_points[$];
  frame_row_t expected_rows[$];
  longint     held_points[9];
  int         held_count = 0;
  int         gap_left = 0;
  int         idle_cycles = 0;
  bit         failed = 1'b0;

  dihedral_angle_and_frame dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .x_coord(x_coord), .y_coord(y_coord), .z_coord(z_coord),
    .row_valid(row_valid), .row_index(row_index),
    .col_x_axis(col_x_axis), .col_y_axis(col_y_axis), .col_z_axis(col_z_axis),
    .col_origin(col_origin), .dihedral(dihedral),
    .degenerate(degenerate), .last_row(last_row)
  );

  always #5 clk = ~clk;

  // Integer square root, bit by bit.
  function automatic longint unsigned root64(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // Unit vector in Q16; returns 0 and zeros for a zero vector.
  function automatic bit unit_vec(input vec3_t s, output vec3_t d);
    longint unsigned mag[3], m, sum, n, q;
    bit neg[3];
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = s[i] < 0;
      mag[i] = neg[i] ? longint'(-s[i]) : s[i];
      if (mag[i] > m) m = mag[i];
    end
    d = '{0, 0, 0};
    if (m == 0) return 1'b0;
    while (m >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      m = m >> 1;
    end
    while (m < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      m = m << 1;
    end
    for (int i = 0; i < 3; i++) sum = sum + mag[i] * mag[i];
    n = root64(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << FRAC) + (n >> 1)) / n;
      d[i] = neg[i] ? -longint'(q) : longint'(q);
    end
    return 1'b1;
  endfunction

  function automatic bit unit_cross(input vec3_t a, input vec3_t b, output vec3_t c);
    vec3_t t;
    t[0] = a[1] * b[2] - a[2] * b[1];
    t[1] = a[2] * b[0] - a[0] * b[2];
    t[2] = a[0] * b[1] - a[1] * b[0];
    return unit_vec(t, c);
  endfunction

  function automatic longint dot3(input vec3_t a, input vec3_t b);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  function automatic longint atan_step(input int i);
    return (i < 10) ? longint'(dhf_pkg::atan_q30(i[4:0])) : (64'sd1 << (30 - i));
  endfunction

  // Arccosine of a Q32 dot product by CORDIC vectoring, result in Q16.
  function automatic longint arc_cosine(input longint dp);
    longint d, x, y, z, t, dx, dy;
    d = dp / 4;
    if (d > (64'sd1 << 30)) d = 64'sd1 << 30;
    if (d < -(64'sd1 << 30)) d = -(64'sd1 << 30);
    x = d;
    y = longint'(root64((64'd1 << 60) - longint'(d * d)));
    z = 0;
    if (x < 0) begin
      t = x;
      x = y;
      y = -t;
      z = HALF_PI_L;
    end
    for (int i = 0; i < dhf_pkg::CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + atan_step(i);
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - atan_step(i);
      end
    end
    if (z < 0) z = 0;
    if (z > PI_Q30_L) z = PI_Q30_L;
    return (z + (64'sd1 << (29 - FRAC))) >>> (30 - FRAC);
  endfunction

  // Stores a point; on the fourth of a set queues the three frame rows.
  task automatic predict_frame(input longint px, input longint py, input longint pz);
    vec3_t p4, dv, prv, zax, nxt, n1, xax, yax, dirv;
    longint angle;
    bit ok;
    frame_row_t row;
    p4 = '{px, py, pz};
    angle = 0;
    if (held_count < 3) begin
      for (int i = 0; i < 3; i++) held_points[held_count * 3 + i] = p4[i];
      held_count++;
      return;
    end
    held_count = 0;
    for (int i = 0; i < 3; i++) dv[i] = held_points[3 + i] - held_points[i];
    ok = unit_vec(dv, prv);
    for (int i = 0; i < 3; i++) dv[i] = held_points[6 + i] - held_points[3 + i];
    ok &= unit_vec(dv, zax);
    for (int i = 0; i < 3; i++) dv[i] = p4[i] - held_points[6 + i];
    ok &= unit_vec(dv, nxt);
    ok &= unit_cross(prv, zax, n1);
    ok &= unit_cross(zax, nxt, xax);
    ok &= unit_cross(zax, xax, yax);
    if (ok) begin
      angle = arc_cosine(dot3(n1, xax));
      // A planar set has no sign direction and keeps the positive angle.
      if (unit_cross(n1, xax, dirv) && dot3(zax, dirv) < 0) angle = -angle;
    end else begin
      xax = '{0, 0, 0};
      yax = '{0, 0, 0};
      zax = '{0, 0, 0};
    end
    for (int r = 0; r < 3; r++) begin
      row.idx   = r[1:0];
      row.xa    = xax[r][17:0];
      row.ya    = yax[r][17:0];
      row.za    = zax[r][17:0];
      row.org   = held_points[6 + r][31:0];
      row.ang   = angle[18:0];
      row.degen = ~ok;
      row.last  = (r == 2);
      expected_rows.push_back(row);
    end
  endtask

  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 19);
    if (k < 12) return 0;
    if (k < 18) return $urandom_range(1, 4);
    return $urandom_range(20, 250);
  endfunction

  // Point driver: holds start until the word is taken, then idles at random.
  always @(posedge clk) begin
    bit     taken;
    point_t p;
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      taken = start && !busy;
      if (taken) predict_frame(x_coord, y_coord, z_coord);
      if (start && !taken) begin
        start <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_points.size() > 0 &&
                   !(pending_points[0].drain && expected_rows.size() > 0)) begin
        p = pending_points.pop_front();
        x_coord <= p.x;
        y_coord <= p.y;
        z_coord <= p.z;
        start <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Row monitor: every strobed word must match the oldest expected row.
  always @(posedge clk) begin
    frame_row_t e;
    if (!rst && row_valid) begin
      if (expected_rows.size() == 0) begin
        $error("row word with no expected row, row_index %0d", row_index);
        failed = 1'b1;
      end else begin
        e = expected_rows.pop_front();
        if (row_index !== e.idx) begin
          $error("row_index expected %0d actual %0d", e.idx, row_index);
          failed = 1'b1;
        end
        if (col_x_axis !== e.xa) begin
          $error("col_x_axis expected %0d actual %0d", e.xa, col_x_axis);
          failed = 1'b1;
        end
        if (col_y_axis !== e.ya) begin
          $error("col_y_axis expected %0d actual %0d", e.ya, col_y_axis);
          failed = 1'b1;
        end
        if (col_z_axis !== e.za) begin
          $error("col_z_axis expected %0d actual %0d", e.za, col_z_axis);
          failed = 1'b1;
        end
        if (col_origin !== e.org) begin
          $error("col_origin expected %0d actual %0d", e.org, col_origin);
          failed = 1'b1;
        end
        if (dihedral !== e.ang) begin
          $error("dihedral expected %0d actual %0d", e.ang, dihedral);
          failed = 1'b1;
        end
        if (degenerate !== e.degen) begin
          $error("degenerate expected %0d actual %0d", e.degen, degenerate);
          failed = 1'b1;
        end
        if (last_row !== e.last) begin
          $error("last_row expected %0d actual %0d", e.last, last_row);
          failed = 1'b1;
        end
      end
    end
  end

  // Watchdog on cycles in which no word moves on either side.
  always @(posedge clk) begin
    if (rst || (start && !busy) || row_valid) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL dihedral_angle_and_frame");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic add_point(input longint px, input longint py, input longint pz,
                           input bit drain_first = 1'b0);
    point_t p;
    p.x = px[31:0];
    p.y = py[31:0];
    p.z = pz[31:0];
    p.drain = drain_first;
    pending_points.push_back(p);
  endtask

  function automatic longint rand_coord(input int shift);
    return longint'($signed($urandom)) >>> shift;
  endfunction

  initial begin
    int     kind, sh;
    longint bx, by, bz, sx, sy, sz;
    localparam longint ONE = 65536;
    localparam longint CMAX = 2147483647;
    localparam longint CMIN = -2147483648;

    // Directed sets: right angle both signs, planar zero and pi, a repeated
    // point, full-scale corners and a collinear chain.
    add_point(ONE, 0, 0); add_point(0, 0, 0); add_point(0, ONE, 0); add_point(0, ONE, ONE);
    add_point(ONE, 0, 0); add_point(0, 0, 0); add_point(0, ONE, 0); add_point(0, ONE, -ONE);
    add_point(ONE, 0, 0); add_point(0, 0, 0); add_point(0, ONE, 0); add_point(ONE, ONE, 0);
    add_point(ONE, 0, 0); add_point(0, 0, 0); add_point(0, ONE, 0); add_point(-ONE, ONE, 0);
    add_point(5, 7, 9); add_point(5, 7, 9); add_point(0, ONE, 0); add_point(ONE, 3, 1);
    add_point(CMAX, CMAX, CMAX); add_point(CMIN, CMIN, CMIN);
    add_point(CMAX, CMIN, CMAX); add_point(CMIN, CMAX, CMIN);
    add_point(0, 0, 0); add_point(ONE, ONE, ONE); add_point(2 * ONE, 2 * ONE, 2 * ONE);
    add_point(3 * ONE, 3 * ONE, 3 * ONE);

    // Random sets, mostly well-formed chains, some noise and broken ones.
    for (int s = 0; s < 38; s++) begin
      kind = $urandom_range(0, 9);
      sh = $urandom_range(0, 20);
      if (kind < 6) begin
        bx = rand_coord(1); by = rand_coord(1); bz = rand_coord(1);
        for (int k = 0; k < 4; k++) begin
          sx = rand_coord(sh + 2); sy = rand_coord(sh + 2); sz = rand_coord(sh + 2);
          add_point((bx + sx) & 64'hFFFF_FFFF, (by + sy) & 64'hFFFF_FFFF,
                    (bz + sz) & 64'hFFFF_FFFF, (s == 20) && (k == 0));
        end
      end else if (kind < 8) begin
        for (int k = 0; k < 4; k++)
          add_point(rand_coord(0), rand_coord(0), rand_coord(0), (s == 20) && (k == 0));
      end else begin
        bx = rand_coord(sh); by = rand_coord(sh); bz = rand_coord(sh);
        add_point(bx, by, bz, s == 20);
        add_point(bx, by, bz);
        add_point(rand_coord(sh), rand_coord(sh), rand_coord(sh));
        add_point(rand_coord(sh), rand_coord(sh), rand_coord(sh));
      end
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    wait (pending_points.size() == 0 && !start && expected_rows.size() == 0);
    repeat (100) @(posedge clk);
    if (!failed && expected_rows.size() == 0) begin
      $display("PASS dihedral_angle_and_frame");
    end else begin
      $display("FAIL dihedral_angle_and_frame");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
sv/dhf_pkg.sv
sv/dhf_isqrt.sv
sv/dhf_cordic.sv
sv/dihedral_angle_and_frame.sv
bench/dihedral_angle_and_frame_test.sv
